// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/spsc_pkg.sv =====
package spsc_pkg;

  // Pulse scaling constants.
  localparam int MIN_PULSE      = 1000;
  localparam int MAX_PULSE      = 5000;
  localparam int MID_PULSE      = 3000;
  localparam int MAX_STEP       = 4092;
  localparam int BROADCAST_CODE = 255;
  localparam int USER_MAX       = 'h03FF;
  localparam int USER_MID       = 'h200;
  localparam int SPAN           = (MAX_PULSE >= MIN_PULSE) ? (MAX_PULSE - MIN_PULSE) : 0;
  localparam int POS_FACTOR     = (SPAN * 16) / USER_MAX;
  localparam int STEP_FACTOR    = MAX_STEP / USER_MAX;
  localparam int USER_FACTOR    = (SPAN == 0) ? 0 : ((USER_MAX * 4096) / SPAN);

  // Command codes.
  localparam logic [3:0] CMD_TICK    = 4'd0;
  localparam logic [3:0] CMD_SET_POS = 4'd1;
  localparam logic [3:0] CMD_SET_STP = 4'd2;
  localparam logic [3:0] CMD_VELOC   = 4'd3;
  localparam logic [3:0] CMD_LIMITS  = 4'd4;
  localparam logic [3:0] CMD_GET_LIM = 4'd5;
  localparam logic [3:0] CMD_GET_POS = 4'd6;
  localparam logic [3:0] CMD_RUN     = 4'd7;
  localparam logic [3:0] CMD_STOP    = 4'd8;

  // One channel's stored state.
  typedef struct packed {
    logic [12:0] pend_tgt;
    logic [11:0] pend_stp;
    logic [12:0] cw;
    logic [12:0] ccw;
    logic        motor;
    logic        drive;
    logic [12:0] live_tgt;
    logic [11:0] live_stp;
    logic [12:0] now_pos;
  } ent_t;

  localparam ent_t ENT_RESET = '{
    pend_tgt: 13'(MID_PULSE), pend_stp: 12'(MAX_STEP),
    cw: 13'(MIN_PULSE), ccw: 13'(MAX_PULSE),
    motor: 1'b0, drive: 1'b0,
    live_tgt: 13'(MID_PULSE), live_stp: 12'(MAX_STEP),
    now_pos: 13'(MID_PULSE)
  };

  // User units to pulse units.
  function automatic logic [12:0] to_pulse(input logic [9:0] v);
    int r;
    r = MIN_PULSE + ((POS_FACTOR * int'(v)) >>> 4);
    return r[12:0];
  endfunction

  // User units to step size.
  function automatic logic [11:0] to_step(input logic [9:0] v);
    int r;
    r = STEP_FACTOR * int'(v);
    return r[11:0];
  endfunction

endpackage

// ===== rtl/servo_pulse_slew_controller_top.sv =====
// Sequence: a tick or single-channel write goes through S_RD and S_MOD to done_o, a
// read back adds S_MUL and S_SAT, a broadcast loops per channel, a reject ends in S_IDLE.
// Throughput: one command at a time; each channel entry costs one read and at most one
// write of the channel state memory, and the next command is taken in the done_o cycle.
// Reset: all channels read as their reset state through per-entry valid bits, slot 0.
// Results appear for one cycle with done_o; the receiver cannot stall.
`include "assert_macros.svh"

module servo_pulse_slew_controller_top
  import spsc_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic [7:0]  channel_i,
  input  logic [15:0] value_a_i,
  input  logic [15:0] value_b_i,
  input  logic        direction_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [9:0]  read_a_o,
  output logic [9:0]  read_b_o,
  output logic        pulse_valid_o,
  output logic [2:0]  pulse_channel_o,
  output logic [7:0]  pin_mask_o,
  output logic [12:0] pulse_width_o
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IW-1:0] LAST_CH = IW'(NUM_CHANNELS - 1);
  localparam logic [22:0] UF = 23'(USER_FACTOR);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [9:0]  a_q, a_d, b_q, b_d;
  logic        dir_q, dir_d, bc_q, bc_d;
  logic [IW-1:0] idx_q, idx_d, last_q, last_d, slot_q, slot_d;
  logic [NUM_CHANNELS-1:0] vld_q, vld_d;
  logic        zero_a_q, zero_a_d, zero_b_q, zero_b_d;
  logic [12:0] diff_a_q, diff_a_d, diff_b_q, diff_b_d;
  logic [35:0] prod_a_q, prod_a_d, prod_b_q, prod_b_d;
  logic        done_q, done_d, ok_q, ok_d, pv_q, pv_d;
  logic [9:0]  ra_q, ra_d, rb_q, rb_d;
  logic [2:0]  pc_q, pc_d;
  logic [7:0]  pm_q, pm_d;
  logic [12:0] pw_q, pw_d;

  ent_t        rdata, ent, went;
  logic        we;

  spsc_ram #(.WIDTH($bits(ent_t)), .DEPTH(NUM_CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (went),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign ent = vld_q[idx_q] ? rdata : ENT_RESET;

  // Saturation of user inputs and command decode.
  logic [9:0]    a_sat, b_sat;
  logic          in_bc, in_single, need;
  logic [IW-1:0] nx_slot;
  assign a_sat     = (|value_a_i[15:10]) ? 10'(USER_MAX) : value_a_i[9:0];
  assign b_sat     = (|value_b_i[15:10]) ? 10'(USER_MAX) : value_b_i[9:0];
  assign in_bc     = (channel_i == 8'(BROADCAST_CODE));
  assign in_single = !in_bc && (32'(channel_i) < NUM_CHANNELS);
  assign nx_slot   = (slot_q == LAST_CH) ? '0 : slot_q + 1'b1;

  always_comb begin
    case (cmd_i)
      CMD_TICK:                                   need = 1'b1;
      CMD_SET_POS, CMD_SET_STP, CMD_VELOC,
      CMD_RUN, CMD_STOP:                          need = in_bc | in_single;
      CMD_LIMITS:                                 need = (in_bc | in_single) && (a_sat <= b_sat);
      CMD_GET_LIM, CMD_GET_POS:                   need = in_single;
      default:                                    need = 1'b0;
    endcase
  end

  // Slew of the served slot toward its target.
  logic [12:0] slew;
  always_comb begin
    slew = ent.now_pos;
    if (ent.live_tgt > ent.now_pos) begin
      slew = ((ent.live_tgt - ent.now_pos) <= {1'b0, ent.live_stp}) ? ent.live_tgt
             : ent.now_pos + {1'b0, ent.live_stp};
    end else if (ent.live_tgt < ent.now_pos) begin
      slew = ((ent.now_pos - ent.live_tgt) <= {1'b0, ent.live_stp}) ? ent.live_tgt
             : ent.now_pos - {1'b0, ent.live_stp};
    end
  end

  logic [3:0]  idx4, pin;
  logic [9:0]  vel_user;
  logic [12:0] clamp;
  assign idx4     = 4'(idx_q);
  assign pin      = idx4 ^ 4'd1;
  assign vel_user = dir_q ? 10'(USER_MID) + {1'b0, a_q[9:1]}
                          : 10'(USER_MID) - {1'b0, a_q[9:1]};
  always_comb begin
    clamp = ent.pend_tgt;
    if (clamp > ent.ccw) clamp = ent.ccw;
    if (clamp < ent.cw)  clamp = ent.cw;
  end

  // Command sequencer.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    a_d      = a_q;
    b_d      = b_q;
    dir_d    = dir_q;
    bc_d     = bc_q;
    idx_d    = idx_q;
    last_d   = last_q;
    slot_d   = slot_q;
    vld_d    = vld_q;
    zero_a_d = zero_a_q;
    zero_b_d = zero_b_q;
    diff_a_d = diff_a_q;
    diff_b_d = diff_b_q;
    prod_a_d = prod_a_q;
    prod_b_d = prod_b_q;
    done_d   = 1'b0;
    ok_d     = ok_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    pv_d     = pv_q;
    pc_d     = pc_q;
    pm_d     = pm_q;
    pw_d     = pw_q;
    we       = 1'b0;
    went     = ent;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          a_d   = a_sat;
          b_d   = b_sat;
          dir_d = direction_i;
          bc_d  = in_bc;
          if (cmd_i == CMD_TICK) begin
            idx_d  = nx_slot;
            last_d = nx_slot;
          end else begin
            idx_d  = in_bc ? '0 : channel_i[IW-1:0];
            last_d = in_bc ? LAST_CH : channel_i[IW-1:0];
          end
          if (need) begin
            state_d = S_RD;
          end else begin
            done_d = 1'b1;
            ok_d   = 1'b0;
            ra_d   = '0;
            rb_d   = '0;
            pv_d   = 1'b0;
            pc_d   = '0;
            pm_d   = '0;
            pw_d   = '0;
          end
        end
      end

      S_RD: begin
        state_d = S_MOD;
      end

      S_MOD: begin
        // Default word: success, nothing read.
        ok_d = 1'b1;
        ra_d = '0;
        rb_d = '0;
        pv_d = 1'b0;
        pc_d = '0;
        pm_d = '0;
        pw_d = '0;
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (cmd_q)
          CMD_TICK: begin
            went.now_pos = slew;
            we     = 1'b1;
            slot_d = idx_q;
            pv_d   = 1'b1;
            pc_d   = idx4[2:0];
            pm_d   = (ent.drive && !pin[3]) ? (8'd1 << pin[2:0]) : '0;
            pw_d   = slew;
          end
          CMD_SET_POS, CMD_VELOC: begin
            if (ent.motor != (cmd_q == CMD_VELOC)) begin
              ok_d = 1'b0;
            end else begin
              we = 1'b1;
              if (cmd_q == CMD_SET_POS) begin
                went.pend_tgt = to_pulse(a_q);
                went.pend_stp = to_step(b_q);
              end else begin
                went.pend_tgt = to_pulse(vel_user);
              end
            end
          end
          CMD_SET_STP: begin
            we            = ent.motor;
            went.pend_stp = to_step(a_q);
            ok_d          = bc_q | ent.motor;
          end
          CMD_LIMITS: begin
            we = 1'b1;
            if (a_q == '0 && b_q == '0) begin
              went.motor = 1'b1;
              went.cw    = to_pulse('0);
              went.ccw   = to_pulse(10'(USER_MAX));
            end else begin
              went.motor = 1'b0;
              went.cw    = to_pulse(a_q);
              went.ccw   = to_pulse(b_q);
            end
          end
          CMD_GET_LIM: begin
            zero_a_d = ent.motor || (SPAN == 0) || (32'(ent.cw) < MIN_PULSE);
            zero_b_d = ent.motor || (SPAN == 0) || (32'(ent.ccw) < MIN_PULSE);
            diff_a_d = ent.cw - 13'(MIN_PULSE);
            diff_b_d = ent.ccw - 13'(MIN_PULSE);
            done_d   = 1'b0;
            state_d  = S_MUL;
          end
          CMD_GET_POS: begin
            zero_a_d = (SPAN == 0) || (32'(ent.now_pos) < MIN_PULSE);
            zero_b_d = 1'b1;
            diff_a_d = ent.now_pos - 13'(MIN_PULSE);
            diff_b_d = '0;
            done_d   = 1'b0;
            state_d  = S_MUL;
          end
          CMD_RUN: begin
            we            = 1'b1;
            went.live_tgt = clamp;
            went.live_stp = ent.pend_stp;
            went.drive    = 1'b1;
          end
          CMD_STOP: begin
            we         = 1'b1;
            went.drive = 1'b0;
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
        if (we) begin
          vld_d[idx_q] = 1'b1;
        end
        // Broadcast walk continues unless a mode check failed.
        if (state_d == S_IDLE && ok_d && idx_q != last_q) begin
          idx_d   = idx_q + 1'b1;
          done_d  = 1'b0;
          state_d = S_RD;
        end
      end

      S_MUL: begin
        prod_a_d = {13'd0, UF} * {23'd0, diff_a_q};
        prod_b_d = {13'd0, UF} * {23'd0, diff_b_q};
        state_d  = S_SAT;
      end

      S_SAT: begin
        ra_d    = zero_a_q ? '0 : ((|prod_a_q[35:22]) ? 10'(USER_MAX) : prod_a_q[21:12]);
        rb_d    = zero_b_q ? '0 : ((|prod_b_q[35:22]) ? 10'(USER_MAX) : prod_b_q[21:12]);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      vld_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    a_q      <= a_d;
    b_q      <= b_d;
    dir_q    <= dir_d;
    bc_q     <= bc_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
    zero_a_q <= zero_a_d;
    zero_b_q <= zero_b_d;
    diff_a_q <= diff_a_d;
    diff_b_q <= diff_b_d;
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    ok_q     <= ok_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    pv_q     <= pv_d;
    pc_q     <= pc_d;
    pm_q     <= pm_d;
    pw_q     <= pw_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign read_a_o        = ra_q;
  assign read_b_o        = rb_q;
  assign pulse_valid_o   = pv_q;
  assign pulse_channel_o = pc_q;
  assign pin_mask_o      = pm_q;
  assign pulse_width_o   = pw_q;

  `ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)
  `ASSERT_IMPL(a_tick_ok, done_o && pulse_valid_o, ok_o)
  `ASSERT_IMPL(a_pin_onehot, done_o, $onehot0(pin_mask_o))
  `ASSERT_IMPL(a_done_idle, done_o, state_q == S_IDLE || state_q == S_RD)

endmodule

// ===== rtl/spsc_ram.sv =====
module spsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
